// ===== design/poly_sin_cos_unit_assert.svh =====
// Assertion macros shared by the sine / cosine unit.
`ifndef POLY_SIN_COS_UNIT_ASSERT_SVH
`define POLY_SIN_COS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/psc_pkg.sv =====
package psc_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 29;
    localparam int OUT_FRAC_BITS_DEF   = 30;

    // Accumulator width, multiplier operand magnitude width, folded angle width.
    localparam int ACC_W = 36;
    localparam int MAG_W = 32;
    localparam int X_W   = 31;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // Q30 coefficients. The highest-order term of each polynomial enters the Horner chain as stored, with no negation.
    localparam logic signed [ACC_W-1:0] ONE_Q30 = 36'sd1073741824;
    localparam logic signed [ACC_W-1:0] SIN_K0  = 36'sd1073740816;
    localparam logic signed [ACC_W-1:0] SIN_K1  = -36'sd178945024;
    localparam logic signed [ACC_W-1:0] SIN_K2  = 36'sd8924834;
    localparam logic signed [ACC_W-1:0] SIN_NK3 = -36'sd198515;
    localparam logic signed [ACC_W-1:0] COS_K0  = 36'sd1073709838;
    localparam logic signed [ACC_W-1:0] COS_K1  = -36'sd536637595;
    localparam logic signed [ACC_W-1:0] COS_K2  = 36'sd44416528;
    localparam logic signed [ACC_W-1:0] COS_NK3 = -36'sd1332771;

    // Control and operands that travel alongside the accumulator.
    typedef struct packed {
        logic             valid;
        logic             cosine;
        logic             negate;
        logic [X_W-1:0]   x;
        logic [MAG_W-1:0] x2;
    } t_side;

    // Pi in the angle format, rounded to nearest.
    function automatic logic [32:0] pi_code(input int unsigned af);
        logic [64:0] t;
        t = {1'b0, PI_Q62} + (65'd1 << (61 - af));
        t = t >> (62 - af);
        return t[32:0];
    endfunction

    // Pi/2 in the angle format, rounded to nearest.
    function automatic logic [32:0] half_code(input int unsigned af);
        logic [64:0] t;
        t = {1'b0, PI_Q62} + (65'd1 << (62 - af));
        t = t >> (63 - af);
        return t[32:0];
    endfunction

endpackage

// ===== design/poly_sin_cos_unit.sv =====
// Channel   Direction  Handshake              Payload
// command   in         start, busy            i_mode, i_angle
// result    out        o_valid (strobe)       o_value
//
// One transaction enters per cycle while busy is low; the result passes through the pipeline:
// two range-reduction stages, five multiply-add steps of two stages each (square, then
// four Horner steps), one output rounding stage.
// busy is high only while reset is asserted; reset clears the valid bits only.
// The result strobe lasts one cycle and cannot be held off, so nothing stalls.
module poly_sin_cos_unit #(
    parameter int ANGLE_FRAC_BITS = psc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = psc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_angle,
    output logic        o_valid,
    output logic [31:0] o_value
);

    localparam logic [32:0] X_MAX =
        psc_pkg::half_code(ANGLE_FRAC_BITS) << (30 - ANGLE_FRAC_BITS);
    localparam logic signed [31:0] O_LIM = 32'sd1 <<< OUT_FRAC_BITS;

    psc_pkg::t_side                      w_side_red;
    psc_pkg::t_side                      w_side_sq;
    psc_pkg::t_side                      w_side_a;
    psc_pkg::t_side                      w_side_b;
    psc_pkg::t_side                      w_side_c;
    psc_pkg::t_side                      w_side_d;
    psc_pkg::t_side                      w_side_e;

    logic signed [psc_pkg::ACC_W-1:0]    w_acc_sq;
    logic signed [psc_pkg::ACC_W-1:0]    w_acc_b;
    logic signed [psc_pkg::ACC_W-1:0]    w_acc_c;
    logic signed [psc_pkg::ACC_W-1:0]    w_acc_d;
    logic signed [psc_pkg::ACC_W-1:0]    w_acc_e;

    logic signed [psc_pkg::ACC_W-1:0]    w_x_acc;
    logic signed [psc_pkg::ACC_W-1:0]    w_top_k;
    logic signed [psc_pkg::ACC_W-1:0]    w_coef_a;
    logic signed [psc_pkg::ACC_W-1:0]    w_coef_b;
    logic signed [psc_pkg::ACC_W-1:0]    w_coef_c;
    logic [psc_pkg::MAG_W-1:0]           w_mult_e;

    assign busy = ~i_rst_n;

    psc_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(start & ~busy),
        .i_mode (i_mode),
        .i_angle(i_angle),
        .o_side (w_side_red)
    );

    assign w_x_acc = $signed(psc_pkg::ACC_W'(w_side_red.x));

    // x squared, with no constant term.
    psc_mac u_square (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_side (w_side_red),
        .i_mult (psc_pkg::MAG_W'(w_side_red.x)),
        .i_acc  (w_x_acc),
        .i_coef ('0),
        .o_side (w_side_sq),
        .o_acc  (w_acc_sq)
    );

    always_comb begin
        w_side_a    = w_side_sq;
        w_side_a.x2 = w_acc_sq[psc_pkg::MAG_W-1:0];
        w_top_k     = w_side_a.cosine ? psc_pkg::COS_NK3 : psc_pkg::SIN_NK3;
        w_coef_a    = w_side_a.cosine ? psc_pkg::COS_K2 : psc_pkg::SIN_K2;
        w_coef_b    = w_side_b.cosine ? psc_pkg::COS_K1 : psc_pkg::SIN_K1;
        w_coef_c    = w_side_c.cosine ? psc_pkg::COS_K0 : psc_pkg::SIN_K0;
        // Sine takes a last factor of x; cosine multiplies by exactly one.
        w_mult_e    = w_side_d.cosine ? psc_pkg::MAG_W'(psc_pkg::ONE_Q30)
                                      : psc_pkg::MAG_W'(w_side_d.x);
    end

    psc_mac u_horner_a (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_side (w_side_a),
        .i_mult (w_side_a.x2),
        .i_acc  (w_top_k),
        .i_coef (w_coef_a),
        .o_side (w_side_b),
        .o_acc  (w_acc_b)
    );

    psc_mac u_horner_b (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_side (w_side_b),
        .i_mult (w_side_b.x2),
        .i_acc  (w_acc_b),
        .i_coef (w_coef_b),
        .o_side (w_side_c),
        .o_acc  (w_acc_c)
    );

    psc_mac u_horner_c (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_side (w_side_c),
        .i_mult (w_side_c.x2),
        .i_acc  (w_acc_c),
        .i_coef (w_coef_c),
        .o_side (w_side_d),
        .o_acc  (w_acc_d)
    );

    psc_mac u_horner_d (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_side (w_side_d),
        .i_mult (w_mult_e),
        .i_acc  (w_acc_d),
        .i_coef ('0),
        .o_side (w_side_e),
        .o_acc  (w_acc_e)
    );

    psc_round #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_round (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_side (w_side_e),
        .i_acc  (w_acc_e),
        .o_valid(o_valid),
        .o_value(o_value)
    );

`include "poly_sin_cos_unit_assert.svh"

    `PSC_ASSERT_IMPL(a_fold_range, i_clk, i_rst_n, w_side_red.valid, {2'b00, w_side_red.x} <= X_MAX, "folded angle beyond a quarter turn")
    `PSC_ASSERT_NEXT(a_last_stage, i_clk, i_rst_n, w_side_e.valid, o_valid, "result strobe lost after the last multiply-add")
    `PSC_ASSERT_IMPL(a_out_range, i_clk, i_rst_n, o_valid, ($signed(o_value) <= O_LIM) && ($signed(o_value) >= -O_LIM), "result outside the unit range")

endmodule

// ===== design/psc_reduce.sv =====
module psc_reduce #(
    parameter int ANGLE_FRAC_BITS = psc_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_mode,
    input  logic [31:0]   i_angle,
    output psc_pkg::t_side o_side
);

    localparam logic [32:0] PI_Q   = psc_pkg::pi_code(ANGLE_FRAC_BITS);
    localparam logic [32:0] TWO_PI = PI_Q << 1;
    localparam logic [32:0] HALF_Q = psc_pkg::half_code(ANGLE_FRAC_BITS);
    localparam int          X_SHIFT = 30 - ANGLE_FRAC_BITS;

    logic        r_v1;
    logic        r_cos1;
    logic        r_neg1;
    logic [31:0] r_red1;

    logic [32:0] w_a;
    logic [32:0] w_clamped;
    logic        w_past;
    logic [32:0] w_red;

    logic [32:0] w_red1;
    logic        w_fold;
    logic [32:0] w_ang;
    logic [32:0] w_x;

    psc_pkg::t_side r_side;

    // Stage 1: clamp to the last code below two pi and remove a half turn from angles past pi.
    always_comb begin
        w_a       = {1'b0, i_angle};
        w_clamped = (w_a >= TWO_PI) ? (TWO_PI - 33'd1) : w_a;
        w_past    = i_mode ? (w_a >= PI_Q) : (w_a > PI_Q);
        w_red     = w_past ? (w_clamped - PI_Q) : w_clamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_cos1 <= i_mode;
        r_neg1 <= w_past;
        r_red1 <= w_red[31:0];
    end

    // Stage 2: fold into the first quadrant; cosine changes sign across the fold.
    always_comb begin
        w_red1 = {1'b0, r_red1};
        w_fold = w_red1 > HALF_Q;
        w_ang  = w_fold ? (PI_Q - w_red1) : w_red1;
        w_x    = w_ang << X_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else begin
            r_side.valid <= r_v1;
        end
        r_side.cosine <= r_cos1;
        r_side.negate <= r_neg1 ^ (w_fold & r_cos1);
        r_side.x      <= w_x[psc_pkg::X_W-1:0];
        r_side.x2     <= '0;
    end

    assign o_side = r_side;

endmodule

// ===== design/psc_mac.sv =====
module psc_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  psc_pkg::t_side                       i_side,
    input  logic [psc_pkg::MAG_W-1:0]            i_mult,
    input  logic signed [psc_pkg::ACC_W-1:0]     i_acc,
    input  logic signed [psc_pkg::ACC_W-1:0]     i_coef,
    output psc_pkg::t_side                       o_side,
    output logic signed [psc_pkg::ACC_W-1:0]     o_acc
);

    localparam int PW = 2 * psc_pkg::MAG_W;
    localparam int RW = PW - 30;

    psc_pkg::t_side                      r_side1;
    logic [PW-1:0]                       r_prod;
    logic                                r_neg;
    logic signed [psc_pkg::ACC_W-1:0]    r_coef;

    psc_pkg::t_side                      r_side2;
    logic signed [psc_pkg::ACC_W-1:0]    r_acc;

    logic [psc_pkg::ACC_W-1:0]           w_abs;
    logic [PW-1:0]                       w_sum;
    logic [RW-1:0]                       w_rnd;
    logic signed [psc_pkg::ACC_W-1:0]    w_mag;
    logic signed [psc_pkg::ACC_W-1:0]    w_term;
    logic signed [psc_pkg::ACC_W-1:0]    n_acc;

    // Stage 1: unsigned product of magnitudes; the multiplier operand is never negative.
    always_comb begin
        w_abs = i_acc[psc_pkg::ACC_W-1] ? (-i_acc) : i_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
        end else begin
            r_side1.valid <= i_side.valid;
        end
        r_side1.cosine <= i_side.cosine;
        r_side1.negate <= i_side.negate;
        r_side1.x      <= i_side.x;
        r_side1.x2     <= i_side.x2;
        r_prod <= PW'(i_mult) * PW'(w_abs[psc_pkg::MAG_W-1:0]);
        r_neg  <= i_acc[psc_pkg::ACC_W-1];
        r_coef <= i_coef;
    end

    // Stage 2: round the magnitude to Q30 (ties away from zero), restore sign, add.
    always_comb begin
        w_sum  = r_prod + (PW'(1) << 29);
        w_rnd  = w_sum[PW-1:30];
        w_mag  = $signed(psc_pkg::ACC_W'(w_rnd));
        w_term = r_neg ? (-w_mag) : w_mag;
        n_acc  = r_coef + w_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side2.valid <= 1'b0;
        end else begin
            r_side2.valid <= r_side1.valid;
        end
        r_side2.cosine <= r_side1.cosine;
        r_side2.negate <= r_side1.negate;
        r_side2.x      <= r_side1.x;
        r_side2.x2     <= r_side1.x2;
        r_acc <= n_acc;
    end

    assign o_side = r_side2;
    assign o_acc  = r_acc;

endmodule

// ===== design/psc_round.sv =====
module psc_round #(
    parameter int OUT_FRAC_BITS = psc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  psc_pkg::t_side                   i_side,
    input  logic signed [psc_pkg::ACC_W-1:0] i_acc,
    output logic                             o_valid,
    output logic [31:0]                      o_value
);

    localparam int SHIFT = 30 - OUT_FRAC_BITS;
    localparam logic [psc_pkg::ACC_W-1:0] ROUND_ADD = (psc_pkg::ACC_W'(1) << SHIFT) >> 1;
    localparam logic [psc_pkg::ACC_W-1:0] LIM       = psc_pkg::ACC_W'(1) << OUT_FRAC_BITS;

    logic                          r_valid;
    logic [31:0]                   r_value;

    logic                          w_sign;
    logic [psc_pkg::ACC_W-1:0]     w_mag;
    logic [psc_pkg::ACC_W-1:0]     w_rnd;
    logic [psc_pkg::ACC_W-1:0]     w_sat;
    logic [psc_pkg::ACC_W-1:0]     w_res;

    // Work in sign and magnitude so the output shift rounds ties away from zero.
    always_comb begin
        w_sign = i_acc[psc_pkg::ACC_W-1] ^ i_side.negate;
        w_mag  = i_acc[psc_pkg::ACC_W-1] ? (-i_acc) : i_acc;
        w_rnd  = (w_mag + ROUND_ADD) >> SHIFT;
        w_sat  = (w_rnd > LIM) ? LIM : w_rnd;
        w_res  = w_sign ? (-w_sat) : w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_side.valid;
        end
        r_value <= w_res[31:0];
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule
